>>> rtl/core/rpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types, codes and tables of the RGB pixel half-float converter.
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int NumChan = 3;

    localparam logic [1:0] FMT_RGBA8   = 2'd0;
    localparam logic [1:0] FMT_RGBA16F = 2'd1;
    localparam logic [1:0] FMT_RGBA32F = 2'd2;

    localparam logic FUNC_DECODE = 1'b0;
    localparam logic FUNC_ENCODE = 1'b1;

    localparam logic [1:0] FMT_RESET = FMT_RGBA16F;
    localparam logic [15:0] ALPHA_ONE = 16'h3c00;

    typedef struct packed {
        logic       func;
        logic [1:0] fmt;
    } t_lane_ctl;

    // Binary32 pattern of byte/255, rounded to nearest.
    function automatic logic [31:0] unorm8_f32(input logic [7:0] b);
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] r;
        logic [31:0] s;
        begin
            if (b == 8'd0) begin
                unorm8_f32 = 32'd0;
            end else begin
                s = 32'd0;
                while ((({56'd0, b} << s) / 64'd255) < 64'h800000) begin
                    s = s + 32'd1;
                end
                num = {56'd0, b} << s;
                q = num / 64'd255;
                r = num % 64'd255;
                if (2 * r > 64'd255) begin
                    q = q + 64'd1;
                end
                if (q >= 64'h1000000) begin
                    q = q >> 1;
                    s = s - 32'd1;
                end
                unorm8_f32 = ((32'd150 - s) << 23) | q[31:0] & 32'h7fffff;
            end
        end
    endfunction

    typedef logic [31:0] t_u8_tab [256];

    function automatic t_u8_tab build_u8_tab();
        t_u8_tab t;
        begin
            for (int i = 0; i < 256; i++) begin
                t[i] = unorm8_f32(i[7:0]);
            end
            build_u8_tab = t;
        end
    endfunction

    localparam t_u8_tab U8_TAB = build_u8_tab();

endpackage

>>> rtl/core/rpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_in_if / rpc_out_if
// Valid/ready channels for pixel items and result items.
// ----------------------------------------------------------------------------
interface rpc_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] chan_red;
    logic [31:0] chan_green;
    logic [31:0] chan_blue;
    modport source(output valid, func, chan_red, chan_green, chan_blue, input ready);
    modport sink(input valid, func, chan_red, chan_green, chan_blue, output ready);
endinterface

interface rpc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] red_bits;
    logic [31:0] green_bits;
    logic [31:0] blue_bits;
    logic [63:0] packed_pixel;
    modport source(output valid, red_bits, green_bits, blue_bits, packed_pixel,
                   input ready);
    modport sink(input valid, red_bits, green_bits, blue_bits, packed_pixel,
                 output ready);
endinterface

>>> rtl/core/rpc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_lane
// One channel: decode to binary32 or encode to clamped binary16.
// ----------------------------------------------------------------------------
module rpc_lane (
    input  rpc_pkg::t_lane_ctl i_ctl,
    input  logic [31:0]        i_chan,
    output logic [31:0]        o_bits
);
    logic [31:0] dec_h;
    logic [31:0] enc_h;
    logic [31:0] f;
    logic [15:0] h;
    logic        nan;
    logic        sgn;
    logic [7:0]  ef;
    logic [22:0] m;
    logic [9:0]  hm;
    logic [4:0]  he;
    logic [4:0]  lz;
    logic [10:0] nm;
    logic [9:0]  e;
    logic [23:0] sh;
    logic [23:0] full;
    logic [4:0]  shamt;

    // Half widening; subnormals are normalized by a leading-one search.
    always_comb begin
        h  = i_chan[15:0];
        he = h[14:10];
        hm = h[9:0];
        lz = 5'd0;
        for (int k = 0; k < 10; k++) begin
            if (hm[k]) begin
                lz = 5'(9 - k);
            end
        end
        nm = {1'b0, hm} << (lz + 5'd1);
        if (he == 5'd0) begin
            if (hm == 10'd0) begin
                dec_h = {h[15], 31'd0};
            end else begin
                dec_h = {h[15], 8'(8'd112 - {3'd0, lz}), nm[9:0], 13'd0};
            end
        end else if (he == 5'h1f) begin
            dec_h = {h[15], 8'hff, hm, 13'd0};
        end else begin
            dec_h = {h[15], 8'({3'd0, he} + 8'd112), hm, 13'd0};
        end
    end

    // Clamp, then round half-up on the magnitude.
    always_comb begin
        f   = i_chan;
        nan = (f[30:23] == 8'hff) && (f[22:0] != 23'd0);
        if (!nan) begin
            if (f[31] && f[30:0] != 31'd0) begin
                f = 32'd0;
            end else if (f == 32'h7f800000) begin
                f = 32'h7f7fffff;
            end
        end
        sgn   = f[31];
        ef    = f[30:23];
        m     = f[22:0];
        e     = 10'({2'd0, ef}) - 10'd112;
        full  = {1'b1, m};
        shamt = 5'd0;
        sh    = 24'd0;
        enc_h = 32'd0;
        if (nan) begin
            enc_h = {16'd0, sgn, 15'h7e00};
        end else if ($signed(e) <= 0) begin
            if ($signed(e) < -10) begin
                enc_h = {16'd0, sgn, 15'd0};
            end else begin
                shamt = 5'(10'd1 - e);
                sh    = full >> shamt;
                enc_h = {16'd0, sgn, 15'(({8'd0, sh} + 32'h1000) >> 13)};
            end
        end else if ($signed(e) >= 31) begin
            enc_h = {16'd0, sgn, 15'h7c00};
        end else begin
            enc_h = {16'd0, sgn, 15'(({e[4:0], 10'd0}) + 15'(({9'd0, m} + 32'h1000) >> 13))};
        end
    end

    always_comb begin
        if (i_ctl.func == rpc_pkg::FUNC_ENCODE) begin
            o_bits = enc_h;
        end else begin
            case (i_ctl.fmt)
                rpc_pkg::FMT_RGBA8:   o_bits = rpc_pkg::U8_TAB[i_chan[7:0]];
                rpc_pkg::FMT_RGBA16F: o_bits = dec_h;
                rpc_pkg::FMT_RGBA32F: o_bits = i_chan;
                default:              o_bits = 32'd0;
            endcase
        end
    end
endmodule

>>> rtl/core/rpc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_merge
// Merges the lane results into one item and holds it in an output register.
// ----------------------------------------------------------------------------
module rpc_merge (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic        i_func,
    input  logic [31:0] i_red,
    input  logic [31:0] i_green,
    input  logic [31:0] i_blue,
    output logic        o_can_load,
    rpc_out_if.source   o_res
);
    logic        r_valid;
    logic [31:0] r_red, r_green, r_blue;
    logic [63:0] r_packed;
    logic [63:0] n_packed;

    assign o_can_load = !r_valid || o_res.ready;
    assign n_packed = (i_func == rpc_pkg::FUNC_ENCODE) ?
        {rpc_pkg::ALPHA_ONE, i_blue[15:0], i_green[15:0], i_red[15:0]} : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_red    <= i_red;
            r_green  <= i_green;
            r_blue   <= i_blue;
            r_packed <= n_packed;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.red_bits     = r_red;
    assign o_res.green_bits   = r_green;
    assign o_res.blue_bits    = r_blue;
    assign o_res.packed_pixel = r_packed;
endmodule

>>> rtl/core/rgb_pixel_half_float_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pixel_half_float_converter_top
// Pixel converter between RGBA8/RGBA16F/RGBA32F and binary32/binary16.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// i_pix     in         func, chan_red, chan_green, chan_blue
// o_res     out        red_bits, green_bits, blue_bits, packed_pixel
// cfg       in         i_cfg_we, i_cfg_wdata (source_format)
//
// One item per clock unless the output stalls; three lanes convert in parallel, result in the next cycle.
// The output register holds a result under stall and refills as it is taken.
// Synchronous active-low reset empties the output and sets format RGBA16F.
// ----------------------------------------------------------------------------
module rgb_pixel_half_float_converter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    rpc_in_if.sink     i_pix,
    rpc_out_if.source  o_res
);
    logic [1:0]         r_fmt;
    rpc_pkg::t_lane_ctl ctl;
    logic [31:0]        lane_bits [rpc_pkg::NumChan];
    logic               can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= rpc_pkg::FMT_RESET;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    assign ctl.func = i_pix.func;
    assign ctl.fmt  = r_fmt;

    rpc_lane u_lane_r (.i_ctl(ctl), .i_chan(i_pix.chan_red),   .o_bits(lane_bits[0]));
    rpc_lane u_lane_g (.i_ctl(ctl), .i_chan(i_pix.chan_green), .o_bits(lane_bits[1]));
    rpc_lane u_lane_b (.i_ctl(ctl), .i_chan(i_pix.chan_blue),  .o_bits(lane_bits[2]));

    assign i_pix.ready = can_load;

    rpc_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_pix.valid),
        .i_func     (i_pix.func),
        .i_red      (lane_bits[0]),
        .i_green    (lane_bits[1]),
        .i_blue     (lane_bits[2]),
        .o_can_load (can_load),
        .o_res      (o_res)
    );

    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> o_res.valid)
        else $error("accepted item did not produce a result");

    a_alpha_on_encode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.packed_pixel != 64'd0 |->
        o_res.packed_pixel[63:48] == rpc_pkg::ALPHA_ONE)
        else $error("packed pixel without alpha one");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.red_bits))
        else $error("stalled result changed");
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel items through the half-float converter in decode and encode
// mode under every source format, with random gaps on both handshakes, and
// compares each result item against an independent predictor.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic [63:0] pixel;
    } t_pixel_result;

    // Binary32 of byte/255, rounded to nearest; computed independently.
    function automatic logic [31:0] byte_to_f32(input logic [7:0] b);
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] r;
        int s;
        if (b == 8'd0) return 32'd0;
        s = 0;
        while (((64'(b) << s) / 64'd255) < 64'h800000) s++;
        num = 64'(b) << s;
        q = num / 64'd255;
        r = num % 64'd255;
        if (2 * r > 64'd255) q++;
        if (q >= 64'h1000000) begin
            q = q >> 1;
            s--;
        end
        return (32'(150 - s) << 23) | (q[31:0] & 32'h7fffff);
    endfunction

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0] e;
        logic [10:0] m;
        int ev;
        sgn = {h[15], 31'd0};
        e = h[14:10];
        m = {1'b0, h[9:0]};
        if (e == 5'd0) begin
            if (m == 11'd0) return sgn;
            ev = 113;
            while (!m[10]) begin
                m = m << 1;
                ev--;
            end
            return sgn | (32'(ev) << 23) | (32'(m[9:0]) << 13);
        end
        if (e == 5'h1f) return sgn | 32'h7f800000 | (32'(m[9:0]) << 13);
        return sgn | ((32'(e) + 32'd112) << 23) | (32'(m[9:0]) << 13);
    endfunction

    function automatic logic [15:0] narrow_clamped(input logic [31:0] f);
        logic is_nan;
        logic [15:0] sgn;
        logic [31:0] m;
        logic [31:0] sh;
        int e;
        is_nan = (f[30:23] == 8'hff) && (f[22:0] != 0);
        if (!is_nan) begin
            if (f[31] && f[30:0] != 0) f = 32'd0;
            else if (f == 32'h7f800000) f = 32'h7f7fffff;
        end
        sgn = {f[31], 15'd0};
        if (is_nan) return sgn | 16'h7e00;
        e = int'(f[30:23]) - 112;
        m = {9'd0, f[22:0]};
        if (e <= 0) begin
            if (e < -10) return sgn;
            sh = (m | 32'h800000) >> (1 - e);
            return sgn | 16'((sh + 32'h1000) >> 13);
        end
        if (e >= 31) return sgn | 16'h7c00;
        return sgn | 16'((32'(e) << 10) + ((m + 32'h1000) >> 13));
    endfunction

    class pixel_scoreboard;
        t_pixel_result pending[$];
        logic [1:0] src_fmt;
        int errors;

        function void note_pixel(logic f, logic [31:0] r, logic [31:0] g,
                                 logic [31:0] b);
            t_pixel_result x;
            logic [31:0] ch[3];
            logic [31:0] o[3];
            ch[0] = r; ch[1] = g; ch[2] = b;
            x.pixel = 64'd0;
            for (int i = 0; i < 3; i++) begin
                if (f == rpc_pkg::FUNC_ENCODE) begin
                    o[i] = {16'd0, narrow_clamped(ch[i])};
                    x.pixel[16*i +: 16] = o[i][15:0];
                end else if (src_fmt == rpc_pkg::FMT_RGBA8) o[i] = byte_to_f32(ch[i][7:0]);
                else if (src_fmt == rpc_pkg::FMT_RGBA16F) o[i] = widen_half(ch[i][15:0]);
                else if (src_fmt == rpc_pkg::FMT_RGBA32F) o[i] = ch[i];
                else o[i] = 32'd0;
            end
            if (f == rpc_pkg::FUNC_ENCODE) x.pixel[63:48] = rpc_pkg::ALPHA_ONE;
            x.red = o[0]; x.green = o[1]; x.blue = o[2];
            pending.push_back(x);
        endfunction

        function void check_result(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                                   logic [63:0] p);
            t_pixel_result x;
            if (pending.size() == 0) begin
                $error("unexpected result item");
                errors++;
                return;
            end
            x = pending.pop_front();
            if (r !== x.red) begin
                $error("red_bits exp %h got %h", x.red, r); errors++;
            end
            if (g !== x.green) begin
                $error("green_bits exp %h got %h", x.green, g); errors++;
            end
            if (b !== x.blue) begin
                $error("blue_bits exp %h got %h", x.blue, b); errors++;
            end
            if (p !== x.pixel) begin
                $error("packed_pixel exp %h got %h", x.pixel, p); errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_wdata = 2'd0;
    rpc_in_if pix_if();
    rpc_out_if res_if();
    pixel_scoreboard board = new();
    int idle_cycles = 0;
    bit stall_enable = 1'b1;

    always #5 i_clk = ~i_clk;

    rgb_pixel_half_float_converter_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_pix(pix_if.sink), .o_res(res_if.source)
    );

    initial begin
        pix_if.valid = 1'b0;
        pix_if.func = 1'b0;
        pix_if.chan_red = 32'd0;
        pix_if.chan_green = 32'd0;
        pix_if.chan_blue = 32'd0;
        res_if.ready = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Receiver: random stalls, checks each accepted result item.
    always @(posedge i_clk) begin
        if (res_if.valid && res_if.ready)
            board.check_result(res_if.red_bits, res_if.green_bits,
                               res_if.blue_bits, res_if.packed_pixel);
        if (!i_rst_n) res_if.ready <= 1'b0;
        else res_if.ready <= !stall_enable || ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Valid stays high between back-to-back items; it drops only for a gap, a format change or the end of the run.
    task automatic send_pixel(input logic f, input logic [31:0] r,
                              input logic [31:0] g, input logic [31:0] b);
        int gap;
        gap = stall_enable ? gap_len() : 0;
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.func <= f;
        pix_if.chan_red <= r;
        pix_if.chan_green <= g;
        pix_if.chan_blue <= b;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        board.note_pixel(f, r, g, b);
    endtask

    task automatic set_format(input logic [1:0] fmt);
        pix_if.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= fmt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.src_fmt = fmt;
    endtask

    function automatic logic [31:0] rand_f32();
        case ($urandom_range(0, 7))
            0: return {1'($urandom_range(0, 1)), 8'hff, 23'(($urandom_range(0, 1))
                       ? $urandom : 0)};
            1: return {1'($urandom_range(0, 1)), 8'($urandom_range(98, 103)),
                       23'($urandom)};
            2: return {1'($urandom_range(0, 1)), 8'($urandom_range(140, 145)),
                       23'($urandom)};
            3, 4, 5: return {1'b0, 8'($urandom_range(101, 143)), 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input logic [1:0] fmt);
        if ($urandom_range(0, 2) == 0)
            send_pixel(rpc_pkg::FUNC_ENCODE, rand_f32(), rand_f32(), rand_f32());
        else if (fmt == rpc_pkg::FMT_RGBA32F && $urandom_range(0, 1))
            send_pixel(rpc_pkg::FUNC_DECODE, rand_f32(), rand_f32(), rand_f32());
        else
            send_pixel(rpc_pkg::FUNC_DECODE, $urandom, $urandom, $urandom);
    endtask

    initial begin
        logic [1:0] fmts[6];
        board.src_fmt = rpc_pkg::FMT_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: half extremes with the reset format, then encode corners.
        send_pixel(rpc_pkg::FUNC_DECODE, 32'hffff0000, 32'h00000001, 32'h000003ff);
        send_pixel(rpc_pkg::FUNC_DECODE, 32'h00007c00, 32'h0000fc01, 32'h00008000);
        send_pixel(rpc_pkg::FUNC_DECODE, 32'h00007bff, 32'h0000ffff, 32'h00000400);
        send_pixel(rpc_pkg::FUNC_ENCODE, 32'h80000000, 32'hff800000, 32'h7f800000);
        send_pixel(rpc_pkg::FUNC_ENCODE, 32'h7fc00001, 32'hffc00000, 32'h33000000);
        send_pixel(rpc_pkg::FUNC_ENCODE, 32'h32ffffff, 32'h477ff000, 32'h477fe000);
        send_pixel(rpc_pkg::FUNC_ENCODE, 32'h387fe000, 32'h3f7ff000, 32'h7f7fffff);
        send_pixel(rpc_pkg::FUNC_ENCODE, 32'h00000001, 32'hbf800000, 32'h3f800000);
        set_format(rpc_pkg::FMT_RGBA8);
        send_pixel(rpc_pkg::FUNC_DECODE, 32'hffffff00, 32'h000000ff, 32'h00000001);
        send_pixel(rpc_pkg::FUNC_DECODE, 32'h00000080, 32'h0000007f, 32'hffffff55);
        set_format(rpc_pkg::FMT_RGBA32F);
        send_pixel(rpc_pkg::FUNC_DECODE, 32'hffffffff, 32'h00000000, 32'h7f800000);
        set_format(2'd3);
        send_pixel(rpc_pkg::FUNC_DECODE, 32'hffffffff, 32'h12345678, 32'h00000001);
        send_pixel(rpc_pkg::FUNC_ENCODE, 32'h3f800000, 32'h40000000, 32'h3e000000);
        fmts = '{rpc_pkg::FMT_RGBA16F, rpc_pkg::FMT_RGBA8, rpc_pkg::FMT_RGBA32F, 2'd3,
                 rpc_pkg::FMT_RGBA16F, rpc_pkg::FMT_RGBA8};
        foreach (fmts[k]) begin
            set_format(fmts[k]);
            stall_enable = (k != 2);
            for (int n = 0; n < 155; n++) send_random(fmts[k]);
        end
        pix_if.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (board.errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
